@@ sv/mmh_pkg.sv @@
`default_nettype none

package mmh_pkg;

    // mixing constants of the x86_32 variant
    localparam logic [31:0] MIX_C1 = 32'hcc9e2d51;
    localparam logic [31:0] MIX_C2 = 32'h1b873593;
    localparam logic [31:0] MIX_N  = 32'he6546b64;
    localparam logic [31:0] FIN_C1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_C2 = 32'hc2b2ae35;

    // register reset values
    localparam logic [31:0] SEED_RESET        = 32'd123;
    localparam logic [4:0]  BUCKET_BITS_RESET = 5'd4;

    // configuration register indexes
    typedef logic [0:0] mmh_cfg_idx_t;
    localparam mmh_cfg_idx_t CFG_SEED        = 1'b0;
    localparam mmh_cfg_idx_t CFG_BUCKET_BITS = 1'b1;

    // command queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);

    // one unit of work handed from front to back
    typedef struct packed {
        logic        start;     // load running hash from seed first
        logic [31:0] seed;
        logic        do_chunk;  // mix a full 4-byte chunk
        logic [31:0] chunk;
        logic        do_final;  // finalize and emit the key's hash
        logic        has_tail;
        logic [23:0] tail;
        logic [31:0] length;
    } mmh_cmd_t;

    // queue status seen by both sides
    typedef struct packed {
        logic           empty;
        logic           full;
        logic [QCW-1:0] count;
    } mmh_qstat_t;

    // back-end sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CK_MUL1,
        ST_CK_MUL2,
        ST_CK_ACC,
        ST_TL_MUL1,
        ST_TL_MUL2,
        ST_TL_ACC,
        ST_FN_MUL1,
        ST_FN_MUL2,
        ST_FN_OUT
    } mmh_state_t;

    function automatic logic [31:0] rotl15(input logic [31:0] v);
        return {v[16:0], v[31:17]};
    endfunction

    function automatic logic [31:0] rotl13(input logic [31:0] v);
        return {v[18:0], v[31:19]};
    endfunction

endpackage

`default_nettype wire

@@ sv/mmh_front.sv @@
`default_nettype none

module mmh_front
    import mmh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // last_byte
    input  wire logic [31:0] seed_i,
    input  wire mmh_qstat_t  q_stat,
    output logic             q_push,
    output mmh_cmd_t         q_cmd
);

    logic        in_key_reg, in_key_next;
    logic        start_pend_reg, start_pend_next;
    logic [31:0] key_seed_reg, key_seed_next;
    logic [23:0] partial_reg, partial_next;
    logic [1:0]  pos_reg, pos_next;
    logic [31:0] len_reg, len_next;

    logic        accept;
    logic        has;
    logic        chunk_done;
    logic [23:0] partial_ins;
    logic [23:0] upd_partial;
    logic [1:0]  upd_pos;
    logic [31:0] upd_len;

    assign s_axis_tready = !q_stat.full;
    assign accept        = s_axis_tvalid && !q_stat.full;
    assign has           = s_axis_tuser;
    assign chunk_done    = has && (pos_reg == 2'd3);

    // place the byte at its little-endian lane
    always_comb begin
        case (pos_reg)
            2'd0:    partial_ins = {16'd0, s_axis_tdata};
            2'd1:    partial_ins = {8'd0, s_axis_tdata, partial_reg[7:0]};
            2'd2:    partial_ins = {s_axis_tdata, partial_reg[15:0]};
            default: partial_ins = partial_reg;
        endcase
    end

    // gather state after this item's byte
    always_comb begin
        upd_partial = partial_reg;
        upd_pos     = pos_reg;
        upd_len     = len_reg;
        if (has) begin
            upd_len = len_reg + 32'd1;
            if (pos_reg == 2'd3) begin
                upd_partial = '0;
                upd_pos     = 2'd0;
            end else begin
                upd_partial = partial_ins;
                upd_pos     = pos_reg + 2'd1;
            end
        end
    end

    // command only for a finished chunk or the key's end
    assign q_push = accept && (chunk_done || s_axis_tlast);

    always_comb begin
        q_cmd.start    = (!in_key_reg && (has || s_axis_tlast)) || start_pend_reg;
        q_cmd.seed     = in_key_reg ? key_seed_reg : seed_i;
        q_cmd.do_chunk = chunk_done;
        q_cmd.chunk    = {s_axis_tdata, partial_reg};
        q_cmd.do_final = s_axis_tlast;
        q_cmd.has_tail = (upd_pos != 2'd0);
        q_cmd.tail     = upd_partial;
        q_cmd.length   = upd_len;
    end

    // next key state
    always_comb begin
        in_key_next     = in_key_reg;
        start_pend_next = start_pend_reg;
        key_seed_next   = key_seed_reg;
        partial_next    = partial_reg;
        pos_next        = pos_reg;
        len_next        = len_reg;
        if (accept) begin
            partial_next = upd_partial;
            pos_next     = upd_pos;
            len_next     = upd_len;
            if (has) begin
                in_key_next = 1'b1;
                if (!in_key_reg) begin
                    key_seed_next   = seed_i;
                    start_pend_next = 1'b1;
                end
            end
            if (q_push) begin
                start_pend_next = 1'b0;
            end
            if (s_axis_tlast) begin
                in_key_next     = 1'b0;
                start_pend_next = 1'b0;
                partial_next    = '0;
                pos_next        = 2'd0;
                len_next        = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_key_reg     <= 1'b0;
            start_pend_reg <= 1'b0;
            partial_reg    <= '0;
            pos_reg        <= 2'd0;
            len_reg        <= '0;
        end else begin
            in_key_reg     <= in_key_next;
            start_pend_reg <= start_pend_next;
            partial_reg    <= partial_next;
            pos_reg        <= pos_next;
            len_reg        <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_seed_reg <= key_seed_next;
    end

endmodule

`default_nettype wire

@@ sv/mmh_cmd_queue.sv @@
`default_nettype none

module mmh_cmd_queue
    import mmh_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  wire mmh_cmd_t push_cmd,
    input  wire logic pop,
    output mmh_cmd_t  head_cmd,
    output mmh_qstat_t stat
);

    mmh_cmd_t       mem_reg [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign stat.count = count_reg;
    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == QCW'(QDEPTH));
    assign head_cmd   = mem_reg[rd_ptr_reg];

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = wr_ptr_reg + QAW'(1);
        end
        if (pop) begin
            rd_ptr_next = rd_ptr_reg + QAW'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + QCW'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QCW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ sv/mmh_back.sv @@
`default_nettype none

module mmh_back
    import mmh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire mmh_qstat_t  q_stat,
    input  wire mmh_cmd_t    q_head,
    output logic             q_pop,
    input  wire logic [4:0]  bucket_bits_i,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata    // [31:0] hash_value, [62:32] bucket_index
);

    mmh_state_t  state_reg, state_next;
    mmh_cmd_t    cmd_reg, cmd_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] prod_reg, prod_next;
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_hash_reg, out_hash_next;
    logic [30:0] out_bucket_reg, out_bucket_next;

    logic [31:0] mul_a;
    logic [31:0] mul_b;
    logic [31:0] mul_full;
    logic [31:0] t0;
    logic [31:0] t1;
    logic [31:0] bucket_mask;

    // one shared 32x32 multiplier, low word kept
    assign mul_full    = mul_a * mul_b;
    assign bucket_mask = (32'd1 << bucket_bits_i) - 32'd1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg        <= cmd_next;
        h_reg          <= h_next;
        prod_reg       <= prod_next;
        out_hash_reg   <= out_hash_next;
        out_bucket_reg <= out_bucket_next;
    end

    // sequencer: chunk mix, tail mix, final avalanche
    always_comb begin
        state_next      = state_reg;
        cmd_next        = cmd_reg;
        h_next          = h_reg;
        prod_next       = prod_reg;
        out_hash_next   = out_hash_reg;
        out_bucket_next = out_bucket_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        q_pop           = 1'b0;
        mul_a           = prod_reg;
        mul_b           = MIX_C1;
        t0              = '0;
        t1              = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop    = 1'b1;
                    cmd_next = q_head;
                    if (q_head.start) begin
                        h_next = q_head.seed;
                    end
                    if (q_head.do_chunk) begin
                        state_next = ST_CK_MUL1;
                    end else if (q_head.has_tail) begin
                        state_next = ST_TL_MUL1;
                    end else begin
                        state_next = ST_FN_MUL1;
                    end
                end
            end
            ST_CK_MUL1: begin
                mul_a      = cmd_reg.chunk;
                mul_b      = MIX_C1;
                prod_next  = mul_full[31:0];
                state_next = ST_CK_MUL2;
            end
            ST_CK_MUL2: begin
                mul_a      = rotl15(prod_reg);
                mul_b      = MIX_C2;
                prod_next  = mul_full[31:0];
                state_next = ST_CK_ACC;
            end
            ST_CK_ACC: begin
                // h * 5 as shift and add
                t0     = rotl13(h_reg ^ prod_reg);
                h_next = {t0[29:0], 2'b00} + t0 + MIX_N;
                if (!cmd_reg.do_final) begin
                    state_next = ST_IDLE;
                end else if (cmd_reg.has_tail) begin
                    state_next = ST_TL_MUL1;
                end else begin
                    state_next = ST_FN_MUL1;
                end
            end
            ST_TL_MUL1: begin
                mul_a      = {8'd0, cmd_reg.tail};
                mul_b      = MIX_C1;
                prod_next  = mul_full[31:0];
                state_next = ST_TL_MUL2;
            end
            ST_TL_MUL2: begin
                mul_a      = rotl15(prod_reg);
                mul_b      = MIX_C2;
                prod_next  = mul_full[31:0];
                state_next = ST_TL_ACC;
            end
            ST_TL_ACC: begin
                h_next     = h_reg ^ prod_reg;
                state_next = ST_FN_MUL1;
            end
            ST_FN_MUL1: begin
                t0         = h_reg ^ cmd_reg.length;
                t1         = t0 ^ (t0 >> 16);
                mul_a      = t1;
                mul_b      = FIN_C1;
                prod_next  = mul_full[31:0];
                state_next = ST_FN_MUL2;
            end
            ST_FN_MUL2: begin
                t0         = prod_reg ^ (prod_reg >> 13);
                mul_a      = t0;
                mul_b      = FIN_C2;
                prod_next  = mul_full[31:0];
                state_next = ST_FN_OUT;
            end
            ST_FN_OUT: begin
                // wait for the output register to free up
                t0 = prod_reg ^ (prod_reg >> 16);
                t1 = t0 & bucket_mask;
                if (!out_valid_reg || m_axis_tready) begin
                    out_valid_next  = 1'b1;
                    out_hash_next   = t0;
                    out_bucket_next = t1[30:0];
                    state_next      = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_bucket_reg, out_hash_reg};

endmodule

`default_nettype wire

@@ sv/murmur3_key_hash_bucket.sv @@
// channel   dir  handshake                    payload
// s_axis    in   s_axis_tvalid/s_axis_tready  tdata key_byte, tuser has_byte, tlast last_byte
// m_axis    out  m_axis_tvalid/m_axis_tready  tdata hash_value, bucket_index
// cfg       in   cfg_we (no ready)            cfg_addr register index, cfg_wdata value
//
// the front takes one item per cycle while the 4-entry command queue has room
// each full chunk takes the back through a pop, two multiplies and an accumulate
// a key end adds an optional tail mix, two finalize multiplies and an output step,
// plus any output stall; the multiplies share the single 32x32 multiplier
// reset is synchronous, active low, and needs no clearing pass
// the output register lets the back finish a key while the last result waits
`default_nettype none

module murmur3_key_hash_bucket
    import mmh_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] key_byte
    input  wire logic        s_axis_tuser,   // [0] has_byte
    input  wire logic        s_axis_tlast,   // last_byte
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [63:0]      m_axis_tdata,   // [31:0] hash_value, [62:32] bucket_index
    input  wire logic        cfg_we,
    input  wire mmh_cfg_idx_t cfg_addr,
    input  wire logic [31:0] cfg_wdata
);

    logic [31:0] seed_reg, seed_next;
    logic [4:0]  bucket_bits_reg, bucket_bits_next;

    mmh_qstat_t  q_stat;
    mmh_cmd_t    q_push_cmd;
    mmh_cmd_t    q_head;
    logic        q_push;
    logic        q_pop;

    // configuration writes
    always_comb begin
        seed_next        = seed_reg;
        bucket_bits_next = bucket_bits_reg;
        if (cfg_we) begin
            unique case (cfg_addr)
                CFG_SEED:        seed_next        = cfg_wdata;
                CFG_BUCKET_BITS: bucket_bits_next = cfg_wdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg        <= SEED_RESET;
            bucket_bits_reg <= BUCKET_BITS_RESET;
        end else begin
            seed_reg        <= seed_next;
            bucket_bits_reg <= bucket_bits_next;
        end
    end

    mmh_front u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .seed_i        (seed_reg),
        .q_stat        (q_stat),
        .q_push        (q_push),
        .q_cmd         (q_push_cmd)
    );

    mmh_cmd_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_cmd (q_push_cmd),
        .pop      (q_pop),
        .head_cmd (q_head),
        .stat     (q_stat)
    );

    mmh_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_stat        (q_stat),
        .q_head        (q_head),
        .q_pop         (q_pop),
        .bucket_bits_i (bucket_bits_reg),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

`ifndef SYNTHESIS
    // no command is written into a full queue
    a_push_not_full: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_stat.full)
        else $error("command pushed into full queue");

    // the back never takes from an empty queue
    a_pop_not_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> !q_stat.empty)
        else $error("command popped from empty queue");

    // fill count stays within depth
    a_count_range: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.count <= QCW'(QDEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire
